// ===== hdl/mffe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the microcode program for the motor feedback front end.
// No dependencies; imported by mffe_seq, mffe_dp and motor_feedback_front_end.
package mffe_pkg;

  // Encoder counts per revolution. Must be a power of two.
  localparam int ENCODER_COUNTS = 4096;
  localparam int ENC_BITS       = $clog2(ENCODER_COUNTS);
  localparam int ADC_WIDTH      = 12;

  localparam int ALPHA_W  = 9;
  localparam int SCALE_W  = 16;
  localparam int POLES_W  = 6;
  localparam int DIV_W    = 8;
  localparam int POS_W    = 16;
  localparam int CUR_W    = 17;
  localparam int FILT_W   = 25;
  localparam int ANGLE_W  = 12;
  localparam int RPM_W    = 24;

  localparam int OPA_W    = 17;
  localparam int OPB_W    = 25;
  localparam int PROD_W   = OPA_W + OPB_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 9'd205;
  localparam logic [SCALE_W-1:0] CSCALE_RESET = 16'd6760;
  localparam logic [POLES_W-1:0] POLES_RESET  = 6'd11;
  localparam logic [DIV_W-1:0]   SDIV_RESET   = 8'd10;
  localparam logic [SCALE_W-1:0] RPM_RESET    = 16'd7500;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 3'd0,
    REG_CSCALE = 3'd1,
    REG_POLES  = 3'd2,
    REG_SDIV   = 3'd3,
    REG_RPM    = 3'd4
  } reg_idx_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    OA_SAMP_A, OA_SAMP_B, OA_ALPHA, OA_NALPHA, OA_POS, OA_MAG
  } opa_t;

  typedef enum logic [2:0] {
    OB_CSCALE, OB_XA, OB_XB, OB_YA, OB_YB, OB_POLES, OB_RPM
  } opb_t;

  // Product write-back destinations
  typedef enum logic [2:0] {
    WB_NONE, WB_XA, WB_XB, WB_ACC, WB_YA, WB_YB, WB_ANGLE, WB_SPEED
  } wb_t;

  typedef enum logic [1:0] {
    BR_NEXT, BR_NOSPD, BR_END
  } br_t;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] END_STEP = 4'd9;

  typedef struct packed {
    opa_t              opa;
    opb_t              opb;
    wb_t               wb;
    br_t               br;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [SCALE_W-1:0] cscale;
    logic [POLES_W-1:0] poles;
    logic [DIV_W-1:0]   sdiv;
    logic [SCALE_W-1:0] rpm;
  } cfg_t;

  typedef struct packed {
    logic [ADC_WIDTH-1:0] samp_a;
    logic [ADC_WIDTH-1:0] samp_b;
    logic [POS_W-1:0]     pos;
    logic [POS_W-1:0]     mag;
    logic                 neg;
    logic                 spd;
  } item_t;

  typedef struct packed {
    logic [CUR_W-1:0]          cur_a;
    logic [CUR_W-1:0]          cur_b;
    logic [ANGLE_W-1:0]        angle;
    logic signed [RPM_W-1:0]   speed;
  } res_t;

  // Binary angle from position modulo one electrical turn
  function automatic logic [ANGLE_W-1:0] to_angle(logic [ENC_BITS-1:0] m);
    logic [ENC_BITS+ANGLE_W-1:0] w;
    w = {m, {ANGLE_W{1'b0}}};
    return w[ENC_BITS+ANGLE_W-1:ENC_BITS];
  endfunction

  // Program: one product per step, written back one step later
  function automatic ctl_t ucode(logic [STEP_W-1:0] s);
    ctl_t w;
    w = '{opa: OA_SAMP_A, opb: OB_CSCALE, wb: WB_NONE, br: BR_END, target: '0};
    case (s)
      4'd0: w = '{opa: OA_SAMP_A, opb: OB_CSCALE, wb: WB_NONE,  br: BR_NEXT,  target: '0};
      4'd1: w = '{opa: OA_SAMP_B, opb: OB_CSCALE, wb: WB_XA,    br: BR_NEXT,  target: '0};
      4'd2: w = '{opa: OA_ALPHA,  opb: OB_XA,     wb: WB_XB,    br: BR_NEXT,  target: '0};
      4'd3: w = '{opa: OA_NALPHA, opb: OB_YA,     wb: WB_ACC,   br: BR_NEXT,  target: '0};
      4'd4: w = '{opa: OA_ALPHA,  opb: OB_XB,     wb: WB_YA,    br: BR_NEXT,  target: '0};
      4'd5: w = '{opa: OA_NALPHA, opb: OB_YB,     wb: WB_ACC,   br: BR_NEXT,  target: '0};
      4'd6: w = '{opa: OA_POS,    opb: OB_POLES,  wb: WB_YB,    br: BR_NEXT,  target: '0};
      4'd7: w = '{opa: OA_MAG,    opb: OB_RPM,    wb: WB_ANGLE, br: BR_NOSPD,
                  target: END_STEP};
      4'd8: w = '{opa: OA_MAG,    opb: OB_RPM,    wb: WB_SPEED, br: BR_NEXT,  target: '0};
      default: w = '{opa: OA_SAMP_A, opb: OB_CSCALE, wb: WB_NONE, br: BR_END, target: '0};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/mffe_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program lookup and branching.
// Depends on mffe_pkg.
module mffe_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           speed_tick,
  input  logic           hold,
  output mffe_pkg::ctl_t ctl,
  output logic           busy,
  output logic           done
);
  import mffe_pkg::*;

  logic [STEP_W-1:0] step, step_next;
  logic              busy_next;
  ctl_t              word;

  always_comb word = ucode(step);

  always_comb begin
    step_next = step;
    busy_next = busy;
    done      = 1'b0;
    ctl       = word;
    if (!busy) begin
      ctl.wb = WB_NONE;
      if (start) begin
        busy_next = 1'b1;
        step_next = '0;
      end
    end else begin
      unique case (word.br)
        BR_NEXT:  step_next = step + 1'b1;
        BR_NOSPD: step_next = speed_tick ? step + 1'b1 : word.target;
        BR_END: begin
          // wait here while the output register is still full
          if (!hold) begin
            done = 1'b1;
            if (start) step_next = '0;
            else       busy_next = 1'b0;
          end
        end
        default: step_next = step + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= END_STEP)
    else $error("sequencer step beyond program end");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done && !start |=> !busy)
    else $error("sequencer still busy after finishing");

  a_idle_no_wb: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ctl.wb == WB_NONE)
    else $error("write-back while sequencer idle");

endmodule

// ===== hdl/mffe_dp.sv =====
`timescale 1ns / 1ps
// Datapath: shared multiplier, product register, filter state and result registers.
// Depends on mffe_pkg; driven by the control word from mffe_seq.
module mffe_dp (
  input  logic            clk,
  input  logic            rst,
  input  mffe_pkg::ctl_t  ctl,
  input  mffe_pkg::item_t item,
  input  mffe_pkg::cfg_t  cfg,
  output mffe_pkg::res_t  res
);
  import mffe_pkg::*;

  logic [ALPHA_W-1:0] alpha_c, nalpha;
  logic [OPA_W-1:0]   opa;
  logic [OPB_W-1:0]   opb;
  logic [PROD_W-1:0]  prod;
  logic [CUR_W-1:0]   xa, xb, x_sat;
  logic [FILT_W-1:0]  acc, ya, yb, y_sat;
  logic [FILT_W:0]    y_sum;
  logic [ANGLE_W-1:0] angle;
  logic signed [RPM_W-1:0] speed, speed_next;
  logic [32:0]        rnd;
  logic [RPM_W:0]     r;

  assign alpha_c = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign nalpha  = ALPHA_ONE - alpha_c;

  always_comb begin
    unique case (ctl.opa)
      OA_SAMP_A: opa = OPA_W'(item.samp_a);
      OA_SAMP_B: opa = OPA_W'(item.samp_b);
      OA_ALPHA:  opa = OPA_W'(alpha_c);
      OA_NALPHA: opa = OPA_W'(nalpha);
      OA_POS:    opa = OPA_W'(item.pos);
      OA_MAG:    opa = OPA_W'(item.mag);
      default:   opa = '0;
    endcase
    unique case (ctl.opb)
      OB_CSCALE: opb = OPB_W'(cfg.cscale);
      OB_XA:     opb = OPB_W'(xa);
      OB_XB:     opb = OPB_W'(xb);
      OB_YA:     opb = ya;
      OB_YB:     opb = yb;
      OB_POLES:  opb = OPB_W'(cfg.poles);
      OB_RPM:    opb = OPB_W'(cfg.rpm);
      default:   opb = '0;
    endcase
  end

  // scaled sample, Q16 amperes, clipped to 17 bits
  assign x_sat = (|prod[PROD_W-1:FILT_W]) ? {CUR_W{1'b1}} : prod[FILT_W-1:8];

  // filter update: alpha*x held in acc plus ((256-alpha)*y) >> 8
  assign y_sum = {1'b0, acc} + prod[FILT_W+8:8];
  assign y_sat = y_sum[FILT_W] ? {FILT_W{1'b1}} : y_sum[FILT_W-1:0];

  // speed: round half away from zero on the magnitude, then apply sign
  assign rnd = {1'b0, prod[31:0]} + 33'd128;
  assign r   = rnd[32:8];

  always_comb begin
    if (item.neg) begin
      if (r > (RPM_W+1)'(1 << (RPM_W-1))) speed_next = {1'b1, {(RPM_W-1){1'b0}}};
      else                                speed_next = -$signed(r[RPM_W-1:0]);
    end else begin
      if (r > (RPM_W+1)'((1 << (RPM_W-1)) - 1)) speed_next = {1'b0, {(RPM_W-1){1'b1}}};
      else                                      speed_next = $signed(r[RPM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    unique case (ctl.wb)
      WB_XA:    xa    <= x_sat;
      WB_XB:    xb    <= x_sat;
      WB_ACC:   acc   <= prod[FILT_W-1:0];
      WB_ANGLE: angle <= to_angle(prod[ENC_BITS-1:0]);
      WB_SPEED: speed <= speed_next;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ya <= '0;
      yb <= '0;
    end else begin
      if (ctl.wb == WB_YA) ya <= y_sat;
      if (ctl.wb == WB_YB) yb <= y_sat;
    end
  end

  assign res.cur_a = ya[FILT_W-1:8];
  assign res.cur_b = yb[FILT_W-1:8];
  assign res.angle = angle;
  assign res.speed = speed;

endmodule

// ===== hdl/motor_feedback_front_end.sv =====
`timescale 1ns / 1ps
// Motor feedback front end: current filters, electrical angle and decimated speed.
// Top level; depends on mffe_pkg, mffe_seq and mffe_dp.
//
// One sample transfer per PWM tick carries two raw phase-current counts and the
// encoder position. Each transfer yields one result transfer with both filtered
// currents, the electrical angle and, every speed_divider-th tick, the speed in
// rpm (speed_valid high; otherwise mech_speed is zero).
// A microcoded sequencer runs the work through one shared 17x25 multiplier, one
// product per cycle while not waiting on its last step; an item with speed takes
// one program step more than one without. result_valid is registered from done.
// sample_stall stays high while an item is in work; the next item may transfer
// in the cycle that the current one finishes.
// The result waits in an output register. If result_stall holds it there when
// the next item finishes, the sequencer waits on its last step.
// Configuration writes (cfg_valid, cfg_ready always high) belong in idle time.
// Synchronous reset restores register defaults and clears filter state, tick
// count and last position; no result is pending after reset.
module motor_feedback_front_end (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mffe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mffe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [mffe_pkg::ADC_WIDTH-1:0]     sample_phase_a,
  input  logic [mffe_pkg::ADC_WIDTH-1:0]     sample_phase_b,
  input  logic [mffe_pkg::POS_W-1:0]         encoder_position,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [mffe_pkg::CUR_W-1:0]         current_a,
  output logic [mffe_pkg::CUR_W-1:0]         current_b,
  output logic [mffe_pkg::ANGLE_W-1:0]       electrical_angle,
  output logic                               speed_valid,
  output logic signed [mffe_pkg::RPM_W-1:0]  mech_speed
);
  import mffe_pkg::*;

  cfg_t              cfg;
  item_t             item;
  res_t              res;
  ctl_t              ctl;
  logic              busy, done, hold, accept, spd_now;
  logic [DIV_W-1:0]  tick_count, count, div;
  logic [POS_W-1:0]  last_position, delta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha  <= ALPHA_RESET;
      cfg.cscale <= CSCALE_RESET;
      cfg.poles  <= POLES_RESET;
      cfg.sdiv   <= SDIV_RESET;
      cfg.rpm    <= RPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA:  cfg.alpha  <= cfg_data[ALPHA_W-1:0];
        REG_CSCALE: cfg.cscale <= cfg_data[SCALE_W-1:0];
        REG_POLES:  cfg.poles  <= cfg_data[POLES_W-1:0];
        REG_SDIV:   cfg.sdiv   <= cfg_data[DIV_W-1:0];
        REG_RPM:    cfg.rpm    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign hold         = result_valid && result_stall;
  assign sample_stall = busy && !done;
  assign accept       = sample_valid && !sample_stall;

  // decimation and position delta are settled at the transfer
  assign count   = tick_count + 1'b1;
  assign div     = (cfg.sdiv == '0) ? DIV_W'(1) : cfg.sdiv;
  assign spd_now = count >= div;
  assign delta   = encoder_position - last_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      last_position <= '0;
    end else if (accept) begin
      tick_count <= spd_now ? '0 : count;
      if (spd_now) last_position <= encoder_position;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.samp_a <= sample_phase_a;
      item.samp_b <= sample_phase_b;
      item.pos    <= encoder_position;
      item.neg    <= delta[POS_W-1];
      item.mag    <= delta[POS_W-1] ? POS_W'(-delta) : delta;
      item.spd    <= spd_now;
    end
  end

  mffe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .speed_tick (item.spd),
    .hold       (hold),
    .ctl        (ctl),
    .busy       (busy),
    .done       (done)
  );

  mffe_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      current_a        <= res.cur_a;
      current_b        <= res.cur_b;
      electrical_angle <= res.angle;
      speed_valid      <= item.spd;
      mech_speed       <= item.spd ? res.speed : '0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> sample_stall)
    else $error("sample taken but sequencer not busy");

  a_tick_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && spd_now |=> tick_count == '0)
    else $error("tick count not cleared on speed tick");

  a_no_speed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !speed_valid |-> mech_speed == '0)
    else $error("speed nonzero on a tick without speed");

endmodule
